[design/gnce_pkg.sv]
// Package for the grid neighbour cell enumerator.
// Holds item structs, register map and field widths; no dependencies.
`default_nettype none
package gnce_pkg;

  localparam int MaxOut   = 64;
  localparam int MaxRange = 24;

  localparam int CoordW = 16;
  localparam int GridW  = 13;
  localparam int RangeW = 5;
  localparam int EntW   = 7;
  localparam int IdxW   = 26;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  typedef enum logic [1:0] {
    RegOriginX = 2'd0,
    RegOriginY = 2'd1,
    RegColumns = 2'd2,
    RegRows    = 2'd3
  } gnce_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [RangeW-1:0] search_range;
    logic [EntW-1:0]   max_entries;
  } gnce_in_t;

  typedef struct packed {
    logic [IdxW-1:0] block_index;
    logic            found;
    logic            last;
  } gnce_out_t;

endpackage
`default_nettype wire

[design/grid_neighbour_cell_enumerator.sv]
// Grid neighbour cell enumerator: top level with APB registers and cell walker.
// Depends on gnce_pkg for item structs, register map and widths.
//
//   channel   direction  handshake                 payload
//   in_item   input      in_valid_i / in_stall_o   gnce_in_t  (position, range, limit)
//   out_item  output     out_valid_o / out_stall_i gnce_out_t (index, found, last)
//   cfg       input      APB psel/penable/pwrite   four grid registers at 4*i
//
// An item runs through the setup states StBounds (bound compute), StMul (column-base
// multiply) and StBase (row-base add), then emits one index per cycle while the output
// is free, then returns to idle to accept the next item; an empty window goes from
// StBounds straight to the empty answer. The walker reloads only when the output
// register is free or being taken, so a stall on the output holds the walk.
// Reset clears the registers to zero and leaves the block idle.
`default_nettype none
module grid_neighbour_cell_enumerator
  import gnce_pkg::*;
#(
  parameter int MAX_OUT   = MaxOut,
  parameter int MAX_RANGE = MaxRange
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // query items
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire gnce_in_t         in_item_i,
  // result items
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output gnce_out_t             out_item_o,
  // register port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  localparam int CntW = $clog2(MAX_OUT + 1);
  localparam int SumW = CoordW + 2;
  localparam int CellW = SumW - 3;

  typedef enum logic [2:0] {
    StIdle,
    StBounds,
    StMul,
    StBase,
    StEmit,
    StEmpty
  } state_e;

  // Configuration registers
  logic [CoordW-1:0] origin_x_q, origin_y_q;
  logic [GridW-1:0]  columns_q, rows_q;

  gnce_reg_e reg_sel;
  assign reg_sel = gnce_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      columns_q  <= '0;
      rows_q     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegOriginX: origin_x_q <= pwdata[CoordW-1:0];
        RegOriginY: origin_y_q <= pwdata[CoordW-1:0];
        RegColumns: columns_q  <= pwdata[GridW-1:0];
        RegRows:    rows_q     <= pwdata[GridW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegOriginX: prdata = DataW'(origin_x_q);
      RegOriginY: prdata = DataW'(origin_y_q);
      RegColumns: prdata = DataW'(columns_q);
      RegRows:    prdata = DataW'(rows_q);
      default:    prdata = '0;
    endcase
  end

  // Walker state
  state_e            st_q;
  logic [CoordW-1:0] pos_x_q, pos_y_q;
  logic [RangeW-1:0] range_q;
  logic [CntW-1:0]   limit_q, count_q;
  logic [GridW-1:0]  xlo_q, xhi_q, ylo_q, yhi_q, cx_q, cy_q;
  logic [IdxW-1:0]   prod_q, row_base_q, idx_q;
  logic              out_valid_q;
  gnce_out_t         out_q;

  // Saturate the query fields on entry
  logic [RangeW-1:0] range_sat;
  logic [EntW-1:0]   limit_sat;
  always_comb begin
    range_sat = (in_item_i.search_range > RangeW'(MAX_RANGE)) ?
                RangeW'(MAX_RANGE) : in_item_i.search_range;
    priority if (in_item_i.max_entries == '0) limit_sat = EntW'(1);
    else if (in_item_i.max_entries > EntW'(MAX_OUT)) limit_sat = EntW'(MAX_OUT);
    else limit_sat = in_item_i.max_entries;
  end

  // Window bounds in cells: floor((pos -/+ range - origin) / 8), then clip to grid
  logic signed [SumW-1:0]  dx_lo, dx_hi, dy_lo, dy_hi;
  logic signed [CellW-1:0] cx_min, cx_max, cy_min, cy_max, cols_s, rows_s;
  logic                    win_empty;
  logic [GridW-1:0]        xlo_c, xhi_c, ylo_c, yhi_c;

  always_comb begin
    dx_lo = $signed({2'b00, pos_x_q}) - $signed(SumW'(range_q)) - $signed({2'b00, origin_x_q});
    dx_hi = $signed({2'b00, pos_x_q}) + $signed(SumW'(range_q)) - $signed({2'b00, origin_x_q});
    dy_lo = $signed({2'b00, pos_y_q}) - $signed(SumW'(range_q)) - $signed({2'b00, origin_y_q});
    dy_hi = $signed({2'b00, pos_y_q}) + $signed(SumW'(range_q)) - $signed({2'b00, origin_y_q});
    cx_min = CellW'(dx_lo >>> 3);
    cx_max = CellW'(dx_hi >>> 3);
    cy_min = CellW'(dy_lo >>> 3);
    cy_max = CellW'(dy_hi >>> 3);
    cols_s = $signed(CellW'(columns_q));
    rows_s = $signed(CellW'(rows_q));
    win_empty = (columns_q == '0) || (rows_q == '0) ||
                (cx_max < 0) || (cx_min >= cols_s) ||
                (cy_max < 0) || (cy_min >= rows_s);
    xlo_c = (cx_min < 0) ? '0 : cx_min[GridW-1:0];
    xhi_c = (cx_max >= cols_s) ? columns_q - GridW'(1) : cx_max[GridW-1:0];
    ylo_c = (cy_min < 0) ? '0 : cy_min[GridW-1:0];
    yhi_c = (cy_max >= rows_s) ? rows_q - GridW'(1) : cy_max[GridW-1:0];
  end

  logic out_free, out_load, row_end, walk_last;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = ((st_q == StEmit) || (st_q == StEmpty)) && out_free;
  assign row_end   = (cx_q == xhi_q);
  assign walk_last = (count_q == limit_q) || (row_end && (cy_q == yhi_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      range_q     <= '0;
      limit_q     <= '0;
      count_q     <= '0;
      xlo_q       <= '0;
      xhi_q       <= '0;
      ylo_q       <= '0;
      yhi_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      prod_q      <= '0;
      row_base_q  <= '0;
      idx_q       <= '0;
    end else begin
      // load a new result, or drop the held one once it is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            pos_x_q <= in_item_i.pos_x;
            pos_y_q <= in_item_i.pos_y;
            range_q <= range_sat;
            limit_q <= CntW'(limit_sat);
            st_q    <= StBounds;
          end
        end
        StBounds: begin
          xlo_q <= xlo_c;
          xhi_q <= xhi_c;
          ylo_q <= ylo_c;
          yhi_q <= yhi_c;
          st_q  <= win_empty ? StEmpty : StMul;
        end
        StMul: begin
          prod_q <= IdxW'({{(IdxW-GridW){1'b0}}, xlo_q} * {{(IdxW-GridW){1'b0}}, rows_q});
          st_q   <= StBase;
        end
        StBase: begin
          row_base_q <= prod_q + IdxW'(ylo_q);
          idx_q      <= prod_q + IdxW'(ylo_q);
          cx_q       <= xlo_q;
          cy_q       <= ylo_q;
          count_q    <= CntW'(1);
          st_q       <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_q.block_index <= idx_q;
            out_q.found       <= 1'b1;
            out_q.last        <= walk_last;
            count_q           <= count_q + CntW'(1);
            if (walk_last) begin
              st_q <= StIdle;
            end else if (row_end) begin
              // advance to the next row, back at the first column
              cx_q       <= xlo_q;
              cy_q       <= cy_q + GridW'(1);
              row_base_q <= row_base_q + IdxW'(1);
              idx_q      <= row_base_q + IdxW'(1);
            end else begin
              // next column: one stride further
              cx_q  <= cx_q + GridW'(1);
              idx_q <= idx_q + IdxW'(rows_q);
            end
          end
        end
        StEmpty: begin
          if (out_free) begin
            out_q <= '{block_index: '0, found: 1'b0, last: 1'b1};
            st_q  <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An empty answer is always the final result of its query
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.last)
    else $error("empty answer without last flag");

  // The column walk stays inside the clipped window
  a_col_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit |-> (cx_q >= xlo_q) && (cx_q <= xhi_q) && (cy_q <= yhi_q))
    else $error("walker left the window");

  // Emitted count never passes the entry limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit |-> (count_q != '0) && (count_q <= limit_q))
    else $error("entry count out of range");

  // A result with last set ends the walk
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit && out_free && walk_last |=> st_q == StIdle)
    else $error("walk continued after last result");

endmodule
`default_nettype wire
